// ----- rtl/stt_pkg.sv -----
// Package: shared types and constants for the sparse triplet transpose block.
`default_nettype none
package stt_pkg;

   localparam int ROW_W       = 10;
   localparam int COL_W       = 10;
   localparam int VALUE_W     = 32;
   localparam int CSR_DATA_W  = 11;
   localparam int CSR_IDX_W   = 1;

   localparam int MAX_TERMS_DEFAULT = 64;
   localparam int MAX_DIM_DEFAULT   = 1024;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'd1;

   localparam logic [CSR_DATA_W-1:0] NUM_ROWS_RESET = 11'd1024;
   localparam logic [CSR_DATA_W-1:0] NUM_COLS_RESET = 11'd1024;

   typedef struct packed {
      logic                      valid;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
   } term_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SHIFT,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/sparse_triplet_transpose_top.sv -----
// Top level: sparse matrix transpose over (row, column, value) triplets.
//
// Terms arrive on the req_ channel, one transaction per cycle while loading.
// Each term drops into a chain of cells kept sorted by column, with equal
// columns in arrival order, so the sort costs nothing at emission time.
// A term with req_last_term set closes the matrix; the block then stops
// accepting and streams the stored terms, swapped, on the rsp_ channel from
// the head cell, one transaction per cycle while rsp_ready is high. The first
// result is offered the cycle after the closing term is accepted. The input
// is held until the last result is taken, receiver stalls included; a matrix
// with nothing to emit just clears the store. Terms with a column at or above
// min(num_cols, MAX_DIM) are stored but not emitted. Terms beyond MAX_TERMS
// are dropped and rsp_overflow is set on every result of that matrix.
// A stalled receiver simply freezes the chain; the result held on the ports
// does not change until taken. Synchronous reset empties the store and sets
// both registers to 1024; csr_ writes take effect at the next edge.
`default_nettype none
module sparse_triplet_transpose_top #(
   parameter int MAX_TERMS = stt_pkg::MAX_TERMS_DEFAULT,
   parameter int MAX_DIM   = stt_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [stt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [stt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [stt_pkg::ROW_W-1:0]         req_row_index,
   input  wire logic [stt_pkg::COL_W-1:0]         req_col_index,
   input  wire logic signed [stt_pkg::VALUE_W-1:0] req_term_value,
   input  wire logic                              req_last_term,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [stt_pkg::COL_W-1:0]              rsp_out_row,
   output logic [stt_pkg::ROW_W-1:0]              rsp_out_col,
   output logic signed [stt_pkg::VALUE_W-1:0]     rsp_out_value,
   output logic                                   rsp_out_last,
   output logic                                   rsp_overflow
);

   logic [stt_pkg::CSR_DATA_W-1:0] num_rows_ff;
   logic [stt_pkg::CSR_DATA_W-1:0] num_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= stt_pkg::NUM_ROWS_RESET;
         num_cols_ff <= stt_pkg::NUM_COLS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            stt_pkg::CSR_NUM_ROWS: num_rows_ff <= csr_wdata;
            stt_pkg::CSR_NUM_COLS: num_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   stt_pkg::term_type      new_term;
   stt_pkg::term_type      cells [MAX_TERMS+1];
   logic                   gts   [MAX_TERMS];
   stt_pkg::cell_ctrl_type ctrl;
   logic                   head_emit, next_emit, dropped;

   assign new_term.valid = 1'b1;
   assign new_term.row   = req_row_index;
   assign new_term.col   = req_col_index;
   assign new_term.value = req_term_value;

   // phantom slot past the tail: always empty
   assign cells[MAX_TERMS]       = '0;

   for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
      stt_pkg::term_type left_term;
      logic              left_gt;
      if (i == 0) begin : g_head
         assign left_term = '0;
         assign left_gt   = 1'b0;
      end else begin : g_body
         assign left_term = cells[i-1];
         assign left_gt   = gts[i-1];
      end
      stt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_term   (new_term),
         .left_term  (left_term),
         .right_term (cells[i+1]),
         .left_gt    (left_gt),
         .term       (cells[i]),
         .gt         (gts[i])
      );
   end

   function automatic logic in_scan(input stt_pkg::term_type t,
                                    input logic [stt_pkg::CSR_DATA_W-1:0] cols);
      return t.valid && ({1'b0, t.col} < cols) && (32'(t.col) < 32'(MAX_DIM));
   endfunction

   // sorted by column, so the first term outside the scan ends the run
   assign head_emit = in_scan(cells[0], num_cols_ff);
   assign next_emit = in_scan(cells[1], num_cols_ff);

   stt_ctrl #(
      .MAX_TERMS (MAX_TERMS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_last_term (req_last_term),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .head_emit     (head_emit),
      .head_last     (!next_emit),
      .dropped       (dropped),
      .ctrl          (ctrl)
   );

   assign rsp_out_row   = cells[0].col;
   assign rsp_out_col   = cells[0].row;
   assign rsp_out_value = cells[0].value;
   assign rsp_out_last  = !next_emit;
   assign rsp_overflow  = dropped;

endmodule
`default_nettype wire

// ----- rtl/stt_cell.sv -----
// Cell: one slot of the column-sorted term chain.
`default_nettype none
module stt_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stt_pkg::cell_ctrl_type ctrl,
   input  wire stt_pkg::term_type  new_term,
   input  wire stt_pkg::term_type  left_term,
   input  wire stt_pkg::term_type  right_term,
   input  wire logic               left_gt,
   output stt_pkg::term_type       term,
   output logic                    gt
);

   stt_pkg::term_type term_ff;
   stt_pkg::term_type term_in;

   // empty slots sort after every key; equal keys keep arrival order
   assign gt = !term_ff.valid || (term_ff.col > new_term.col);

   always_comb begin
      term_in = term_ff;
      case (ctrl.op)
         stt_pkg::OP_INSERT: begin
            if (gt) begin
               term_in = left_gt ? left_term : new_term;
            end
         end
         stt_pkg::OP_SHIFT: term_in = right_term;
         stt_pkg::OP_CLEAR: term_in.valid = 1'b0;
         default:           term_in = term_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff.valid <= 1'b0;
      end else begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule
`default_nettype wire

// ----- rtl/stt_ctrl.sv -----
// Controller: load and emit sequencing, term count and dropped flag.
`default_nettype none
module stt_ctrl #(
   parameter int MAX_TERMS = stt_pkg::MAX_TERMS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_last_term,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic               head_emit,
   input  wire logic               head_last,
   output logic                    dropped,
   output stt_pkg::cell_ctrl_type  ctrl
);

   localparam int CNT_W = $clog2(MAX_TERMS + 1);

   stt_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic               full;
   logic               req_fire;

   assign full     = (count_ff == CNT_W'(MAX_TERMS));
   assign req_fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stt_pkg::ST_LOAD: begin
            if (req_valid && req_last_term) begin
               state_in = stt_pkg::ST_EMIT;
            end
         end
         stt_pkg::ST_EMIT: begin
            if (!head_emit || (rsp_ready && head_last)) begin
               state_in = stt_pkg::ST_LOAD;
            end
         end
         default: state_in = stt_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      ctrl.op    = stt_pkg::OP_HOLD;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         stt_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_fire) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  ctrl.op  = stt_pkg::OP_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         stt_pkg::ST_EMIT: begin
            rsp_valid = head_emit;
            // drop the whole store once the run ends
            if (!head_emit || (rsp_ready && head_last)) begin
               ctrl.op    = stt_pkg::OP_CLEAR;
               count_in   = '0;
               dropped_in = 1'b0;
            end else if (rsp_ready) begin
               ctrl.op = stt_pkg::OP_SHIFT;
            end
         end
         default: ctrl.op = stt_pkg::OP_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= stt_pkg::ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign dropped = dropped_ff;

endmodule
`default_nettype wire
